### sv/gcmb_pkg.sv
package gcmb_pkg;

   // block geometry
   localparam int SLOT_BYTES  = 16;
   localparam int BLOCK_SLOTS = 4096;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = BLOCK_SLOTS / WORD_BITS;
   localparam int WIDX_W      = $clog2(MAP_WORDS);
   localparam int BIDX_W      = $clog2(WORD_BITS);
   localparam int SLOT_W      = WIDX_W + BIDX_W;
   localparam int SCNT_W      = SLOT_W + 1;
   localparam int SHIFT       = $clog2(SLOT_BYTES);

   localparam logic [16:0] BLOCK_BYTES = 17'(BLOCK_SLOTS * SLOT_BYTES);
   localparam logic [16:0] USED_RESET  = 17'd65536;

   // operation codes
   typedef enum logic [2:0] {
      OP_NEW_CYCLE = 3'd0,
      OP_RECORD    = 3'd1,
      OP_MARK      = 3'd2,
      OP_TEST      = 3'd3,
      OP_RANGE     = 3'd4,
      OP_SWEEP     = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] offset;
      logic [16:0] end_offset;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] cell_offset;
      logic [16:0] cell_size;
      logic        sweep_done;
   } rsp_type;

   // control of one bitmap memory
   typedef struct packed {
      logic              rd_en;
      logic [WIDX_W-1:0] rd_addr;
      logic              wr_en;
      logic [WIDX_W-1:0] wr_addr;
      logic              clear;
   } map_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_EVAL,
      ST_HOLD
   } state_type;

   // sweep step phases
   typedef enum logic [1:0] {
      PH_FIRST,
      PH_NEXT,
      PH_MARKS
   } phase_type;

endpackage

### sv/gc_mark_bitmap_sweeper.sv
// new cycle, record start, mark and test: one registered read, no new request until done
// range check: reads 64-slot bitmap words (one word per cycle, early exit)
// sweep step: three word scans (next start, following start, marks)
// sweep step with no start left: only the first scan
// the word rate is set by the single read port of each bitmap memory
// synchronous reset clears marks, starts and sweep cursor at once, used_bytes resets to 65536
module gc_mark_bitmap_sweeper import gcmb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [2:0]           op_ff, op_in;
   logic [SCNT_W-1:0]    lo_ff, lo_in;
   logic [SCNT_W-1:0]    hi_ff, hi_in;
   logic [WIDX_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    s_ff, s_in;
   logic [WORD_BITS-1:0] sw_ff, sw_in;
   logic [16:0]          cend_ff, cend_in;
   logic [16:0]          cursor_ff, cursor_in;
   logic [16:0]          used_ff;
   rsp_type              hold_ff, hold_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 accept;
   logic                 can_load;
   logic                 load;
   logic                 finish;
   rsp_type              res;
   rsp_type              load_data;

   logic [16:0]          lim;
   logic [17:0]          lim_sum;
   logic [SCNT_W-1:0]    lim_slot;
   logic [17:0]          cur_sum;
   logic [SCNT_W-1:0]    s0;
   logic [17:0]          end_sum;
   logic [17-SHIFT:0]    end_raw;
   logic [SCNT_W-1:0]    end_slot;
   logic [SCNT_W-1:0]    req_slot;

   logic [WORD_BITS-1:0] mark_word;
   logic [WORD_BITS-1:0] start_word;
   logic [WORD_BITS-1:0] scan_word;
   logic [WORD_BITS-1:0] scan_mask;
   logic [WORD_BITS-1:0] masked;
   logic [WORD_BITS-1:0] bit_mask;
   logic [SCNT_W-1:0]    hm1;
   logic [BIDX_W-1:0]    pos;
   logic                 empty;
   logic                 scan_found;
   logic                 scan_end;
   logic                 mark_bit;

   logic                 rd_en;
   logic [WIDX_W-1:0]    rd_addr;
   logic [WIDX_W-1:0]    wr_addr;
   logic                 mark_wr_en;
   logic                 start_wr_en;
   logic                 mark_clear;
   logic [WORD_BITS-1:0] mark_wr_data;
   logic [WORD_BITS-1:0] start_wr_data;
   map_ctl_type          mark_ctl;
   map_ctl_type          start_ctl;

   // lowest set bit of a word
   function automatic logic [BIDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [BIDX_W-1:0] p;
      p = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            p = BIDX_W'(i);
         end
      end
      return p;
   endfunction

   // bitmap memories
   gcmb_map_ram u_mark_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mark_ctl),
      .wr_data (mark_wr_data),
      .rd_data (mark_word)
   );

   gcmb_map_ram u_start_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (start_ctl),
      .wr_data (start_wr_data),
      .rd_data (start_word)
   );

   assign mark_ctl  = '{rd_en: rd_en, rd_addr: rd_addr, wr_en: mark_wr_en,
                        wr_addr: wr_addr, clear: mark_clear};
   assign start_ctl = '{rd_en: rd_en, rd_addr: rd_addr, wr_en: start_wr_en,
                        wr_addr: wr_addr, clear: 1'b0};

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // slot bounds of the request
   assign lim      = (used_ff > BLOCK_BYTES) ? BLOCK_BYTES : used_ff;
   assign lim_sum  = {1'b0, lim} + 18'(SLOT_BYTES - 1);
   assign lim_slot = SCNT_W'(lim_sum >> SHIFT);
   assign cur_sum  = {1'b0, cursor_ff} + 18'(SLOT_BYTES - 1);
   assign s0       = SCNT_W'(cur_sum >> SHIFT);
   assign end_sum  = {1'b0, req_data.end_offset} + 18'(SLOT_BYTES - 1);
   assign end_raw  = end_sum[17:SHIFT];
   assign end_slot = (end_raw > (18-SHIFT)'(BLOCK_SLOTS)) ? SCNT_W'(BLOCK_SLOTS)
                                                          : SCNT_W'(end_raw);
   // a 16-bit offset always falls inside the block
   assign req_slot = {1'b0, req_data.offset[15:SHIFT]};

   // word scan over slots [lo, hi)
   assign scan_word = (op_type'(op_ff) == OP_SWEEP && phase_ff != PH_MARKS) ? start_word
                                                                              : mark_word;
   assign empty     = (lo_ff >= hi_ff);
   assign hm1       = SCNT_W'(hi_ff - 1'b1);

   always_comb begin
      scan_mask = '1;
      if (idx_ff == lo_ff[SLOT_W-1:BIDX_W]) begin
         scan_mask = scan_mask & ({WORD_BITS{1'b1}} << lo_ff[BIDX_W-1:0]);
      end
      if (idx_ff == hm1[SLOT_W-1:BIDX_W]) begin
         scan_mask = scan_mask &
                     ({WORD_BITS{1'b1}} >> (BIDX_W'(WORD_BITS - 1) - hm1[BIDX_W-1:0]));
      end
   end

   assign masked     = scan_word & scan_mask;
   assign pos        = lowest_set(masked);
   assign scan_found = !empty && (masked != '0);
   assign scan_end   = empty || scan_found || (idx_ff == hm1[SLOT_W-1:BIDX_W]);

   // single slot access
   assign bit_mask = WORD_BITS'(1) << lo_ff[BIDX_W-1:0];
   assign mark_bit = mark_word[lo_ff[BIDX_W-1:0]];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      s_in          = s_ff;
      sw_in         = sw_ff;
      cend_in       = cend_ff;
      cursor_in     = cursor_ff;
      hold_in       = hold_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_addr       = lo_ff[SLOT_W-1:BIDX_W];
      mark_wr_en    = 1'b0;
      start_wr_en   = 1'b0;
      mark_clear    = 1'b0;
      mark_wr_data  = mark_word | bit_mask;
      start_wr_data = start_word | bit_mask;
      res           = '0;
      finish        = 1'b0;
      load          = 1'b0;
      load_data     = hold_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data.operation;
               phase_in = PH_FIRST;
               if (op_type'(req_data.operation) == OP_SWEEP) begin
                  lo_in = s0;
                  hi_in = lim_slot;
               end else begin
                  lo_in = req_slot;
                  hi_in = end_slot;
               end
               rd_en    = 1'b1;
               rd_addr  = lo_in[SLOT_W-1:BIDX_W];
               idx_in   = rd_addr;
               state_in = ST_EVAL;
            end
         end

         // start a new scan phase at lo
         ST_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = lo_ff[SLOT_W-1:BIDX_W];
            idx_in   = rd_addr;
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            unique case (op_type'(op_ff))
               OP_NEW_CYCLE: begin
                  mark_clear = 1'b1;
                  cursor_in  = '0;
                  finish     = 1'b1;
               end
               OP_RECORD: begin
                  start_wr_en = 1'b1;
                  finish      = 1'b1;
               end
               OP_MARK: begin
                  res.hit    = !mark_bit;
                  mark_wr_en = !mark_bit;
                  finish     = 1'b1;
               end
               OP_TEST: begin
                  res.hit = mark_bit;
                  finish  = 1'b1;
               end
               OP_RANGE: begin
                  if (scan_end) begin
                     res.hit = scan_found;
                     finish  = 1'b1;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = WIDX_W'(idx_ff + 1'b1);
                     idx_in  = rd_addr;
                  end
               end
               OP_SWEEP: begin
                  if (!scan_end) begin
                     rd_en   = 1'b1;
                     rd_addr = WIDX_W'(idx_ff + 1'b1);
                     idx_in  = rd_addr;
                  end else begin
                     unique case (phase_ff)
                        // next cell start at or above the cursor
                        PH_FIRST: begin
                           if (!scan_found) begin
                              res.sweep_done = 1'b1;
                              finish         = 1'b1;
                           end else begin
                              s_in     = {idx_ff, pos};
                              sw_in    = start_word;
                              lo_in    = SCNT_W'({1'b0, idx_ff, pos} + 1'b1);
                              phase_in = PH_NEXT;
                              state_in = ST_ISSUE;
                           end
                        end
                        // following start bounds the cell, else used_bytes capped at the block size
                        PH_NEXT: begin
                           if (scan_found) begin
                              cend_in = {1'b0, idx_ff, pos, {SHIFT{1'b0}}};
                              hi_in   = {1'b0, idx_ff, pos};
                           end else begin
                              cend_in = lim;
                           end
                           lo_in    = {1'b0, s_ff};
                           phase_in = PH_MARKS;
                           state_in = ST_ISSUE;
                        end
                        // any mark inside the cell keeps it live
                        PH_MARKS: begin
                           res.hit         = scan_found;
                           res.cell_offset = {s_ff, {SHIFT{1'b0}}};
                           res.cell_size   = cend_ff - {1'b0, s_ff, {SHIFT{1'b0}}};
                           cursor_in       = cend_ff;
                           if (!scan_found) begin
                              start_wr_en   = 1'b1;
                              wr_addr       = s_ff[SLOT_W-1:BIDX_W];
                              start_wr_data = sw_ff & ~(WORD_BITS'(1) << s_ff[BIDX_W-1:0]);
                           end
                           finish = 1'b1;
                        end
                        default: begin
                           finish = 1'b1;
                        end
                     endcase
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end

         // result waits for the output register
         ST_HOLD: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase

      if (finish) begin
         if (can_load) begin
            load      = 1'b1;
            load_data = res;
            state_in  = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_HOLD;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FIRST;
         cursor_ff    <= '0;
         used_ff      <= USED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         cursor_ff <= cursor_in;
         if (csr_valid && csr_ready) begin
            used_ff <= csr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      s_ff    <= s_in;
      sw_ff   <= sw_in;
      cend_ff <= cend_in;
      hold_ff <= hold_in;
      if (load) begin
         rsp_data_ff <= load_data;
      end
   end

endmodule

### sv/gcmb_map_ram.sv
module gcmb_map_ram import gcmb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  map_ctl_type          ctl,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] q_ff;
   logic [MAP_WORDS-1:0] vld_ff;
   logic [MAP_WORDS-1:0] vld_in;
   logic                 qv_ff;

   // word storage, one write and one registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         q_ff <= mem[ctl.rd_addr];
      end
   end

   // row valid bits, a row never written reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end else if (ctl.wr_en) begin
         vld_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (ctl.rd_en) begin
            qv_ff <= vld_ff[ctl.rd_addr];
         end
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule
